// ===== rtl/fra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_pkg
// Item types, operation and status codes, and sequencer states for the
// fraction arithmetic and reduction unit.
// ----------------------------------------------------------------------------
package fra_pkg;

    localparam int unsigned IN_BITS = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_ZERO_NUM = 2'd2;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [IN_BITS-1:0]  a_num;
        logic signed [IN_BITS-1:0]  a_den;
        logic signed [IN_BITS-1:0]  b_num;
        logic signed [IN_BITS-1:0]  b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [32:0] res_num;
        logic signed [31:0] res_den;
        logic [1:0]         status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_PREP,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_FIN
    } state_t;

endpackage

// ===== rtl/fraction_arith_reduce_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_arith_reduce_unit
// Adds, subtracts, multiplies or divides two signed fractions and, when
// neither part is zero, reduces the result by the gcd of both parts.
// ----------------------------------------------------------------------------
// One item at a time. An item is taken in the idle state, its products are
// formed on the shared multiplier (S_MUL0 to S_MUL2), the result is combined
// and classified (S_PREP, S_CHECK), reduced by binary gcd (one
// compare/subtract/shift per cycle, a subtract always followed by at least one
// shift) and divided by the gcd in the shared restoring divider (numerator,
// then denominator), and handed over in S_FIN, which waits while an earlier
// result is still unread. When a part of the result is zero, the gcd and the
// divider are skipped. in_ready is high only while the unit is idle; a
// finished item waits in the output register, so the next item can be taken
// before the last one is read.
// ----------------------------------------------------------------------------
module fraction_arith_reduce_unit #(
    parameter int OPERAND_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fra_pkg::in_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fra_pkg::out_item_t   out_item
);
    import fra_pkg::*;

    localparam int OW   = OPERAND_BITS;
    localparam int PW   = 2 * OW;          // product width
    localparam int NW   = PW + 1;          // combined numerator width
    localparam int MAGW = PW;              // magnitude width
    localparam int KW   = $clog2(MAGW + 1);
    localparam int CW   = $clog2(MAGW);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAGW - 1);

    // operand: low OW bits of the input field, sign extended from bit OW-1
    function automatic logic signed [OW-1:0] ext_op(input logic [IN_BITS-1:0] raw);
        logic [OW+IN_BITS-1:0] wide;
        wide = {{OW{1'b0}}, raw};
        return $signed(wide[OW-1:0]);
    endfunction

    state_t state_reg, state_next;

    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, out_item_next;

    logic [1:0]         op_reg, op_next;
    logic signed [OW-1:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [OW-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic signed [PW-1:0] t0_reg, t0_next, t1_reg, t1_next, d_reg, d_next;
    logic signed [NW-1:0] num_reg, num_next;
    logic signed [PW-1:0] den_reg, den_next;
    logic [1:0]         stat_reg, stat_next;
    logic               neg_reg, neg_next;
    logic [MAGW-1:0]    x_reg, x_next, y_reg, y_next;
    logic [MAGW-1:0]    nmag_reg, nmag_next, dmag_reg, dmag_next;
    logic [MAGW-1:0]    g_reg, g_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [MAGW:0]      rem_reg, rem_next;
    logic [MAGW-1:0]    quo_reg, quo_next;
    logic [CW-1:0]      cnt_reg, cnt_next;

    // shared multiplier
    logic signed [OW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    always_comb
    begin
        case (state_reg)
            S_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            S_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // combine and magnitude logic
    logic signed [NW-1:0] t0_ext, t1_ext, num_comb, num_neg;
    logic signed [PW-1:0] den_neg;

    assign t0_ext  = {t0_reg[PW-1], t0_reg};
    assign t1_ext  = {t1_reg[PW-1], t1_reg};
    assign num_neg = -num_reg;
    assign den_neg = -den_reg;

    always_comb
    begin
        case (op_reg)
            OP_ADD:  num_comb = t0_ext + t1_ext;
            OP_SUB:  num_comb = t0_ext - t1_ext;
            default: num_comb = t0_ext;
        endcase
    end

    // shared restoring divider step
    logic [MAGW:0]   div_shift, div_sub;
    logic            div_ge;
    logic [MAGW:0]   div_rem;
    logic [MAGW-1:0] div_quo;

    assign div_shift = {rem_reg[MAGW-1:0], quo_reg[MAGW-1]};
    assign div_ge    = div_shift >= {1'b0, g_reg};
    assign div_sub   = div_shift - {1'b0, g_reg};
    assign div_rem   = div_ge ? div_sub : div_shift;
    assign div_quo   = {quo_reg[MAGW-2:0], div_ge};

    // result formatting
    logic signed [MAGW:0] qn_signed;
    logic signed [63:0]   qn_wide, raw_wide;
    logic [63:0]          qd_wide;

    assign qn_signed = neg_reg ? -$signed({1'b0, x_reg}) : $signed({1'b0, x_reg});
    assign qn_wide   = {{(64 - MAGW - 1){qn_signed[MAGW]}}, qn_signed};
    assign raw_wide  = {{(64 - NW){num_reg[NW-1]}}, num_reg};
    assign qd_wide   = {{(64 - MAGW){1'b0}}, quo_reg};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        op_next   = op_reg;
        an_next   = an_reg;
        ad_next   = ad_reg;
        bn_next   = bn_reg;
        bd_next   = bd_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        d_next    = d_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        stat_next = stat_reg;
        neg_next  = neg_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        nmag_next = nmag_reg;
        dmag_next = dmag_reg;
        g_next    = g_reg;
        k_next    = k_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_item.req_type;
                    an_next    = ext_op(in_item.a_num);
                    ad_next    = ext_op(in_item.a_den);
                    bn_next    = ext_op(in_item.b_num);
                    bd_next    = ext_op(in_item.b_den);
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                t0_next    = prod;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                t1_next    = prod;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                d_next     = prod;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                num_next   = num_comb;
                den_next   = d_reg;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                nmag_next = num_reg[NW-1] ? num_neg[MAGW-1:0] : num_reg[MAGW-1:0];
                dmag_next = den_reg[PW-1] ? den_neg : den_reg;
                x_next    = nmag_next;
                y_next    = dmag_next;
                k_next    = '0;
                neg_next  = num_reg[NW-1] ^ den_reg[PW-1];
                if (den_reg == '0)
                begin
                    stat_next  = ST_ZERO_DEN;
                    state_next = S_FIN;
                end
                else if (num_reg == '0)
                begin
                    stat_next  = ST_ZERO_NUM;
                    state_next = S_FIN;
                end
                else
                begin
                    stat_next  = ST_OK;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                // binary gcd: one shift or one subtract per cycle
                if (x_reg == y_reg)
                begin
                    g_next     = x_reg << k_reg;
                    quo_next   = nmag_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIVN;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_reg > y_reg)
                begin
                    x_next = x_reg - y_reg;
                end
                else
                begin
                    y_next = y_reg - x_reg;
                end
            end
            S_DIVN:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    x_next     = div_quo;     // reduced numerator magnitude
                    quo_next   = dmag_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_item_next.status = stat_reg;
                    case (stat_reg)
                        ST_ZERO_DEN:
                        begin
                            out_item_next.res_num = raw_wide[32:0];
                            out_item_next.res_den = '0;
                        end
                        ST_ZERO_NUM:
                        begin
                            out_item_next.res_num = '0;
                            out_item_next.res_den = 32'sd1;
                        end
                        default:
                        begin
                            out_item_next.res_num = qn_wide[32:0];
                            out_item_next.res_den = qd_wide[31:0];
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        op_reg   <= op_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        d_reg    <= d_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        stat_reg <= stat_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        nmag_reg <= nmag_next;
        dmag_reg <= dmag_next;
        g_reg    <= g_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        cnt_reg  <= cnt_next;
    end

endmodule
